>>> hw/rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// Integer literal parser package
// Shared types, character codes and digit helpers for the parser datapath.
// ----------------------------------------------------------------------------
package ilp_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;

    // Marker for a character that is no hex digit
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Size classes
    localparam logic [2:0] SIZE_NONE = 3'd0;
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RC_DEC = 2'd0,
        RC_OCT = 2'd1,
        RC_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        phase_t      phase;
        radix_t      radix;
        logic        negative;
        logic [31:0] acc;
        logic        digit_seen;
    } parse_state_t;

    typedef struct packed {
        logic              valid_res;
        logic signed [31:0] value;
        logic [2:0]        size_bytes;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:      PH_START,
        radix:      RC_DEC,
        negative:   1'b0,
        acc:        32'd0,
        digit_seen: 1'b0
    };

    // Digit value in either case, or DIGIT_NONE
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_base(input radix_t r);
        logic [4:0] b;
        case (r)
            RC_OCT:  b = 5'd8;
            RC_HEX:  b = 5'd16;
            default: b = 5'd10;
        endcase
        return b;
    endfunction

    // Accumulator times radix, built from shifts, modulo 2^32
    function automatic logic [31:0] scale_acc(input logic [31:0] a, input radix_t r);
        logic [31:0] s;
        case (r)
            RC_OCT:  s = {a[28:0], 3'b000};
            RC_HEX:  s = {a[27:0], 4'b0000};
            default: s = {a[28:0], 3'b000} + {a[30:0], 1'b0};
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/ilp_step.sv
// ----------------------------------------------------------------------------
// Integer literal parser step
// Next parse state and terminator result for one character.
// ----------------------------------------------------------------------------
module ilp_step (
    input  ilp_pkg::parse_state_t  cur,
    input  logic [7:0]             ch,
    output ilp_pkg::parse_state_t  nxt,
    output ilp_pkg::parse_result_t res
);
    import ilp_pkg::*;

    radix_t      sel_radix;
    logic [4:0]  dval;
    logic        dig_ok;
    logic [31:0] mac;
    logic        tok_ok;

    // Pick the radix a digit is checked against in this phase
    always_comb begin
        if (cur.phase == PH_START || cur.phase == PH_SIGNED) begin
            sel_radix = RC_DEC;
        end else begin
            sel_radix = cur.radix;
        end
    end

    // Digit check and multiply-accumulate
    assign dval   = digit_value(ch);
    assign dig_ok = (dval < radix_base(sel_radix));
    assign mac    = scale_acc(cur.acc, sel_radix) + {28'd0, dval[3:0]};

    assign tok_ok = (cur.phase == PH_START || cur.phase == PH_SIGNED ||
                     cur.phase == PH_ZERO  || cur.phase == PH_DIGITS) && cur.digit_seen;

    // Advance the parse state, emit the result on the terminator
    always_comb begin
        nxt = cur;
        res = '0;
        if (ch == CH_NUL) begin
            nxt = STATE_RESET;
            if (tok_ok) begin
                res.valid_res = 1'b1;
                res.value     = cur.negative ? -cur.acc : cur.acc;
                if (cur.acc[31:8] == 24'd0) begin
                    res.size_bytes = SIZE_BYTE;
                end else if (cur.acc[31:16] == 16'd0) begin
                    res.size_bytes = SIZE_HALF;
                end else begin
                    res.size_bytes = SIZE_WORD;
                end
            end else begin
                res.size_bytes = SIZE_NONE;
            end
        end else begin
            unique case (cur.phase)
                PH_START, PH_SIGNED: begin
                    if (cur.phase == PH_START && ch == CH_MINUS) begin
                        nxt.negative = 1'b1;
                        nxt.phase    = PH_SIGNED;
                    end else if (ch == CH_ZERO) begin
                        nxt.radix      = RC_OCT;
                        nxt.digit_seen = 1'b1;
                        nxt.acc        = 32'd0;
                        nxt.phase      = PH_ZERO;
                    end else begin
                        nxt.radix = RC_DEC;
                        if (dig_ok) begin
                            nxt.acc        = mac;
                            nxt.digit_seen = 1'b1;
                            nxt.phase      = PH_DIGITS;
                        end else begin
                            nxt.phase = PH_ERROR;
                        end
                    end
                end
                PH_ZERO: begin
                    if (ch == CH_LOW_X) begin
                        nxt.radix      = RC_HEX;
                        nxt.digit_seen = 1'b0;
                        nxt.phase      = PH_DIGITS;
                    end else if (dig_ok) begin
                        nxt.acc        = mac;
                        nxt.digit_seen = 1'b1;
                        nxt.phase      = PH_DIGITS;
                    end else begin
                        nxt.phase = PH_ERROR;
                    end
                end
                PH_DIGITS: begin
                    if (dig_ok) begin
                        nxt.acc        = mac;
                        nxt.digit_seen = 1'b1;
                        nxt.phase      = PH_DIGITS;
                    end else begin
                        nxt.phase = PH_ERROR;
                    end
                end
                default: begin
                    nxt.phase = PH_ERROR;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ilp_out_buf.sv
// ----------------------------------------------------------------------------
// Integer literal parser output buffer
// Result register with valid/ready hold toward the receiver.
// ----------------------------------------------------------------------------
module ilp_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  ilp_pkg::parse_result_t load_res,
    output logic                   can_load,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ilp_pkg::parse_result_t res_out
);
    import ilp_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    parse_result_t res_reg;

    // Free when empty or when the held beat leaves this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

>>> hw/rtl/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// Integer literal parser
// Parses decimal, octal and hex integer tokens one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one ASCII character per beat on s_ch; a zero
//   character ends the token. Only the terminator produces a beat on the
//   m_ channel: m_valid_res, the signed m_value and m_size_bytes (0, 1, 2 or 4).
//   Characters pass an input register, then the parse logic updates the
//   token state; a terminator loads the result register.
//   A terminator is held in the input register, then loaded into the
//   result register that drives m_valid. Throughput: one character per
//   cycle while no terminator waits on a full result register; the rate
//   rests on the combinational shift-and-add accumulator update. When the
//   receiver stalls, other characters keep flowing; a terminator waits in
//   the input register, with s_ready low, until the result register frees up.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the token state to the start of a token, positive, decimal, zero.
// ----------------------------------------------------------------------------
module integer_literal_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_ch,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_valid_res,
    output logic signed [31:0] m_value,
    output logic [2:0]         m_size_bytes
);
    import ilp_pkg::*;

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    ch_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    parse_result_t out_res;
    logic          is_term;
    logic          out_free;
    logic          stage_fire;

    // Process the held character unless it is a terminator facing a full output
    assign is_term    = (ch_reg == CH_NUL);
    assign stage_fire = in_valid_reg && (!is_term || out_free);
    assign s_ready    = !in_valid_reg || stage_fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (stage_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
    end

    // Token state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (stage_fire) begin
            state_reg <= state_next;
        end
    end

    ilp_step u_step (
        .cur (state_reg),
        .ch  (ch_reg),
        .nxt (state_next),
        .res (step_res)
    );

    ilp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (stage_fire && is_term),
        .load_res (step_res),
        .can_load (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (out_res)
    );

    assign m_valid_res  = out_res.valid_res;
    assign m_value      = out_res.value;
    assign m_size_bytes = out_res.size_bytes;

`ifndef ASSERT_OFF
    // Invalid tokens carry zero value and size
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_value == 32'sd0 && m_size_bytes == SIZE_NONE)
        else $error("invalid result with nonzero payload");

    // Valid tokens carry a legal size class
    a_valid_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |->
            m_size_bytes == SIZE_BYTE || m_size_bytes == SIZE_HALF ||
            m_size_bytes == SIZE_WORD)
        else $error("valid result with bad size class");

    // A processed terminator returns the token state to its start
    a_term_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && is_term |=>
            state_reg.phase == PH_START && state_reg.acc == 32'd0 &&
            !state_reg.negative && !state_reg.digit_seen)
        else $error("token state not cleared after terminator");

    // Input stalls only with a terminator waiting on a full output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && is_term && m_valid && !m_ready)
        else $error("input stalled without cause");
`endif

endmodule
